### rtl/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int DATA_W     = 32;
    localparam int CAPACITY_W = 5;

    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

    // returned on a get miss
    localparam logic [DATA_W-1:0] MISS_DATA = 32'hFFFF_FFFF;
    // returned by every put
    localparam logic [DATA_W-1:0] PUT_DATA  = 32'h0000_0000;

    // operation codes (func field)
    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;   // capture the accepted word
        logic exec;      // lookup, LRU update, value RAM access
        logic load_out;  // move the result into the output register
    } lkvc_cmd_t;

endpackage

### rtl/lkvc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lkvc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: capture, execute, respond; owns both handshakes.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output lkvc_pkg::lkvc_cmd_t cmd
);

    import lkvc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && out_free);
    assign accept   = s_tvalid && s_tready;

    assign cmd.load_in  = accept;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.load_out = (state_reg == ST_RESP) && out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) state_next = accept ? ST_EXEC : ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

### rtl/lkvc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath
// Key tags, recency ranks, occupancy, value RAM and output register.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
    parameter int ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lkvc_pkg::lkvc_cmd_t               cmd,
    input  logic                              cfg_we,
    input  logic [lkvc_pkg::CAPACITY_W-1:0]   cfg_wdata,
    input  logic                              in_func,
    input  logic [lkvc_pkg::KEY_W-1:0]        in_key,
    input  logic [lkvc_pkg::VALUE_W-1:0]      in_value,
    output logic                              out_hit,
    output logic [lkvc_pkg::DATA_W-1:0]       out_data
);

    import lkvc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAPACITY_W) ? OCC_W : CAPACITY_W;

    // config
    logic [CAPACITY_W-1:0] capacity_reg;

    // captured word
    logic               func_in_reg;
    logic [KEY_W-1:0]   key_in_reg;
    logic [VALUE_W-1:0] value_in_reg;

    // tag store; rank 0 = most recent
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]   rank_reg  [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [OCC_W-1:0]   occ_reg, occ_next;

    // result of the execute step
    logic hit_q_reg;
    logic func_q_reg;

    // output register
    logic              out_hit_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] old_match;
    logic [ENTRIES-1:0] kept;
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   hit_rank;
    logic [IDX_W-1:0]   old_idx;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   old_rank;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   eff_cap;
    logic               evict;
    logic               insert;
    logic [DATA_W-1:0]  ram_rdata;

    // effective capacity: zero acts as one, clipped to the entry count
    always_comb begin
        cap_ext = CMP_W'(capacity_reg);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            eff_cap = CMP_W'(ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    // LRU entry carries rank occupancy-1
    assign old_rank = IDX_W'(occ_reg - OCC_W'(1));

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]     = valid_reg[i] && (key_reg[i] == key_in_reg);
            old_match[i] = valid_reg[i] && (rank_reg[i] == old_rank);
        end
    end

    // lowest-numbered match wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        old_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (old_match[i]) begin
                old_idx = IDX_W'(i);
            end
        end
    end

    assign hit_rank = rank_reg[hit_idx];
    assign insert   = (func_in_reg == FUNC_PUT) && !hit;
    assign evict    = insert && (CMP_W'(occ_reg) >= eff_cap);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            kept[i] = valid_reg[i] && !(evict && (IDX_W'(i) == old_idx));
        end
    end

    always_comb begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!kept[i]) free_idx = IDX_W'(i);
        end
    end

    // recency / valid / occupancy update
    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        occ_next   = occ_reg;
        if (cmd.exec) begin
            if (hit) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (valid_reg[i] && (IDX_W'(i) != hit_idx) && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_next[hit_idx] = '0;
            end else if (insert) begin
                for (int i = 0; i < ENTRIES; i++) begin
                    valid_next[i] = kept[i];
                    if (kept[i]) rank_next[i] = rank_reg[i] + IDX_W'(1);
                end
                valid_next[free_idx] = 1'b1;
                rank_next[free_idx]  = '0;
                occ_next = evict ? occ_reg : occ_reg + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            valid_reg    <= '0;
            occ_reg      <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) capacity_reg <= cfg_wdata;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_in_reg  <= in_func;
            key_in_reg   <= in_key;
            value_in_reg <= in_value;
        end
        if (cmd.exec) begin
            hit_q_reg  <= hit;
            func_q_reg <= func_in_reg;
            if (insert) key_reg[free_idx] <= key_in_reg;
        end
        if (cmd.load_out) begin
            out_hit_reg <= hit_q_reg;
            if (func_q_reg == FUNC_PUT) begin
                out_data_reg <= PUT_DATA;
            end else if (hit_q_reg) begin
                out_data_reg <= ram_rdata;
            end else begin
                out_data_reg <= MISS_DATA;
            end
        end
    end

    lkvc_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (ENTRIES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (cmd.exec && (func_in_reg == FUNC_PUT)),
        .waddr (hit ? hit_idx : free_idx),
        .wdata (value_in_reg),
        .re    (cmd.exec),
        .raddr (hit_idx),
        .rdata (ram_rdata)
    );

    assign out_hit  = out_hit_reg;
    assign out_data = out_data_reg;

endmodule

### rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Flow: the input word is captured, then the execute step runs, then the
// registered read of the value RAM moves into the output register; the next
// word can be taken while a result is loaded into the output register.
// Reset (aresetn low, synchronous): cache empty, capacity = 16, no result
// pending. No clearing pass; valid bits live in flops.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    // capacity register, write only
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,

    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] key, [63:32] value
    input  logic [0:0]  s_tuser,   // [0] func (0 get, 1 put)

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] data
    output logic [0:0]  m_tuser    // [0] hit
);

    import lkvc_pkg::*;

    lkvc_cmd_t cmd;

    // Controller: IDLE takes a word; EXEC does the tag compare, rank
    // update and value RAM access; RESP loads the output register and
    // may take the next word in the same cycle. RESP holds while the
    // previous result has not been drained, so the RAM read data stays.
    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Datapath: keys, ranks and valid bits in flops for the parallel
    // compare; values in a small RAM addressed by the hit or free slot.
    // The LRU victim is the valid entry whose rank is occupancy-1.
    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_func   (s_tuser[0]),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .out_hit   (m_tuser[0]),
        .out_data  (m_tdata)
    );

endmodule

### tb/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key/value cache. A behavioral copy of the
// cache runs beside the block and predicts hit and data for every accepted
// request word. Results are checked in order. The run covers directed corner
// cases and random get/put traffic over several capacities and idle mixes.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int SETTLE_CYC  = 8;        // margin after the last result
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] data;
    } cache_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;   // [31:0] key, [63:32] value
    logic [0:0]  s_tuser   = '0;   // [0] func
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;          // [31:0] data
    logic [0:0]  m_tuser;          // [0] hit

    lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Shadow cache: same replacement policy, kept in step with accepted words
    // ------------------------------------------------------------------------
    logic [KEY_W-1:0]      shadow_key   [ENTRIES];
    logic [VALUE_W-1:0]    shadow_value [ENTRIES];
    bit                    shadow_valid [ENTRIES];
    int unsigned           shadow_age   [ENTRIES];  // 0 = most recent
    int                    shadow_fill;
    logic [CAPACITY_W-1:0] shadow_capacity;

    cache_result_t pending_results[$];
    int            error_count = 0;
    int            idle_pct    = 0;   // sender gap chance, percent
    int            stall_pct   = 0;   // receiver stall chance, percent
    int            cycle_count = 0;

    // zero acts as one, anything past the array size saturates
    function automatic int clamp_capacity(logic [CAPACITY_W-1:0] cap);
        if (cap == 0)
            return 1;
        if (cap > ENTRIES)
            return ENTRIES;
        return cap;
    endfunction

    function automatic int lookup_slot(logic [KEY_W-1:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && shadow_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void promote_slot(int s);
        for (int i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && i != s && shadow_age[i] < shadow_age[s])
                shadow_age[i]++;
        shadow_age[s] = 0;
    endfunction

    function automatic cache_result_t predict_access(logic op, logic [KEY_W-1:0] key,
                                                     logic [VALUE_W-1:0] value);
        cache_result_t r;
        int s;
        int oldest;
        int free_slot;
        s = lookup_slot(key);
        if (op == FUNC_GET) begin
            if (s >= 0) begin
                promote_slot(s);
                r.hit  = 1'b1;
                r.data = shadow_value[s];
            end else begin
                r.hit  = 1'b0;
                r.data = MISS_DATA;
            end
            return r;
        end
        r.data = PUT_DATA;
        r.hit  = (s >= 0);
        if (s >= 0) begin
            shadow_value[s] = value;
            promote_slot(s);
            return r;
        end
        // insert: evict one LRU entry if full (also when capacity was lowered)
        if (shadow_fill >= clamp_capacity(shadow_capacity)) begin
            oldest = -1;
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
                    oldest = i;
            if (oldest >= 0) begin
                shadow_valid[oldest] = 1'b0;
                shadow_fill--;
            end
        end
        free_slot = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
            if (!shadow_valid[i])
                free_slot = i;
        if (free_slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++)
                if (shadow_valid[i])
                    shadow_age[i]++;
            shadow_key[free_slot]   = key;
            shadow_value[free_slot] = value;
            shadow_valid[free_slot] = 1'b1;
            shadow_age[free_slot]   = 0;
            shadow_fill++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random backpressure and in-order compare
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cache_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing pending, expected none, got hit=%0b data=%h",
                         $time, m_tuser[0], m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit) begin
                    error_count++;
                    $display("%0t: hit mismatch, expected %0b, got %0b",
                             $time, want.hit, m_tuser[0]);
                end
                if (m_tdata !== want.data) begin
                    error_count++;
                    $display("%0t: data mismatch, expected %h, got %h",
                             $time, want.data, m_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers
    // ------------------------------------------------------------------------
    // tvalid stays high after a transfer so back-to-back words follow without a
    // gap; whoever waits next pulls it low first.
    task automatic send_word(logic op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {value, key};
        s_tuser[0] <= op;
        do
            @(posedge aclk);
        while (!s_tready);
        pending_results.push_back(predict_access(op, key, value));
    endtask

    // wait until every result is back and the pipeline has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAPACITY_W-1:0] cap);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        shadow_capacity = cap;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Get on empty cache, then 17 distinct inserts with capacity 31 (clamped
    // to 16), so the first key falls out. Extreme keys and values included.
    task automatic test_fill_past_capacity();
        logic [31:0] corner_keys [4];
        logic [31:0] corner_vals [4];
        corner_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
        corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        write_capacity(5'd31);
        send_word(FUNC_GET, corner_keys[0], 32'h0);
        for (int i = 0; i < 17; i++) begin
            if (i < 4)
                send_word(FUNC_PUT, corner_keys[i], corner_vals[i]);
            else
                send_word(FUNC_PUT, 32'h0000_1000 + i, 32'h5A5A_0000 + i);
        end
        send_word(FUNC_GET, corner_keys[0], 32'hFFFF_FFFF);
        send_word(FUNC_GET, corner_keys[1], 32'h0);
    endtask

    // put to a present key reports a hit and replaces the value
    task automatic test_overwrite();
        send_word(FUNC_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_word(FUNC_GET, 32'hFFFF_FFFF, 32'h0);
    endtask

    // capacity dropped under a full cache: each insert evicts exactly one
    task automatic test_capacity_lowered();
        write_capacity(5'd2);
        send_word(FUNC_PUT, 32'h0000_2000, 32'hCAFE_0001);
        send_word(FUNC_GET, 32'h0000_1004, 32'h0);
        send_word(FUNC_GET, 32'h0000_2000, 32'h0);
    endtask

    // capacity zero behaves as one
    task automatic test_capacity_zero();
        write_capacity(5'd0);
        send_word(FUNC_PUT, 32'h0000_3000, 32'hBEEF_0002);
        send_word(FUNC_GET, 32'h0000_3000, 32'h0);
        send_word(FUNC_GET, 32'h0000_2000, 32'h0);
    endtask

    // Random gets and puts. Most keys come from a pool slightly larger than
    // the capacity so hits, refreshes and evictions all happen; the rest are
    // fully random keys. Halfway through, the sender drains the pipe.
    task automatic test_random_traffic(int gap_pct, int hold_pct,
                                       logic [CAPACITY_W-1:0] cap, int count);
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        int pool_n;
        write_capacity(cap);
        idle_pct  = gap_pct;
        stall_pct = hold_pct;
        pool_n = clamp_capacity(cap) + 1 + $urandom_range(6);
        for (int i = 0; i < pool_n; i++)
            key_pool.push_back($urandom);
        for (int n = 0; n < count; n++) begin
            if (n == count / 2)
                settle();
            if ($urandom_range(99) < 85)
                key = key_pool[$urandom_range(pool_n - 1)];
            else
                key = $urandom;
            send_word($urandom_range(1) ? FUNC_PUT : FUNC_GET, key, $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_age[i]   = 0;
        end
        shadow_fill     = 0;
        shadow_capacity = CAPACITY_RESET;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fill_past_capacity();
        test_overwrite();
        test_capacity_lowered();
        test_capacity_zero();

        test_random_traffic(0,  0,  5'd5,  84);
        test_random_traffic(48, 0,  5'd16, 84);
        test_random_traffic(0,  48, 5'd1,  84);
        test_random_traffic(22, 22, 5'd31, 84);
        test_random_traffic(0,  0,  5'd3,  84);
        test_random_traffic(48, 0,  5'd17, 84);
        test_random_traffic(0,  48, 5'd0,  84);
        test_random_traffic(22, 22, 5'd10, 84);

        settle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
